@@ sv/mbps_pkg.sv @@
package mbps_pkg;

    // Widest pattern the compare logic supports
    localparam int PAT_MAX_BYTES = 16;
    localparam int LEN_W         = 5;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_PATTERN_LOW  = 3'd0,
        CFG_PATTERN_HIGH = 3'd1,
        CFG_COMPARE_MASK = 3'd2,
        CFG_PATTERN_LEN  = 3'd3
    } t_cfg_reg;

    // Compare setup broadcast to every window cell
    typedef struct packed {
        logic [8*PAT_MAX_BYTES-1:0] pattern;
        logic [PAT_MAX_BYTES-1:0]   mask;
        logic [LEN_W-1:0]           len;     // effective length, 1..16
    } t_match_cfg;

endpackage

@@ sv/mbps_cell.sv @@
module mbps_cell #(
    parameter int POS = 0
) (
    input  logic                   i_clk,
    input  logic                   i_shift,
    input  logic [7:0]             i_byte,
    input  mbps_pkg::t_match_cfg   i_cfg,
    output logic [7:0]             o_byte,
    output logic                   o_hit
);

    logic [7:0] r_byte;

    // Window byte, moves one cell further on each transfer
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

    // Compare the byte this cell takes on the transfer
    if (POS < mbps_pkg::PAT_MAX_BYTES) begin : g_cmp
        logic       in_use;
        logic [3:0] j;
        logic       care;
        logic [7:0] pbyte;

        always_comb begin
            in_use = ({1'b0, i_cfg.len} > 6'(POS));
            j      = 4'(i_cfg.len - 5'd1 - 5'(POS));
            care   = i_cfg.mask[j];
            pbyte  = i_cfg.pattern[{j, 3'b000} +: 8];
            o_hit  = !in_use || !care || (i_byte == pbyte);
        end
    end else begin : g_no_cmp
        assign o_hit = 1'b1;
    end

endmodule

@@ sv/masked_byte_pattern_scan_unit.sv @@
// A result is valid in the cycle after the transfer of a region's last byte.
// Throughput: one byte per cycle unless the input stalls; the compare runs in parallel
// across the window cells in the cycle of the transfer, so no loop limits the rate.
// Results sit in one output register; input stalls only while it is full and stalled.
// Reset (synchronous, active low) clears control state and loads the register reset values.
module masked_byte_pattern_scan_unit #(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // byte stream
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic [63:0] i_region_base,
    input  logic        i_first_of_region,
    input  logic        i_last_of_region,
    // results
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_match_found,
    output logic [63:0] o_match_address
);

    localparam int CAP = (MAX_PATTERN_BYTES < mbps_pkg::PAT_MAX_BYTES) ?
                         MAX_PATTERN_BYTES : mbps_pkg::PAT_MAX_BYTES;
    localparam int FW  = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int CW  = (FW > mbps_pkg::LEN_W) ? FW : mbps_pkg::LEN_W;

    // Configuration registers
    logic [63:0] r_pat_lo;
    logic [63:0] r_pat_hi;
    logic [15:0] r_mask;
    logic [4:0]  r_len;

    // Region state
    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;
    logic [63:0]   r_cur_addr;
    logic          r_found;
    logic [63:0]   r_found_addr;
    logic          n_found;
    logic [63:0]   n_found_addr;

    // Output register
    logic        r_out_valid;
    logic        r_out_found;
    logic [63:0] r_out_addr;

    logic                 in_xfer;
    logic [4:0]           eff_len;
    logic [63:0]          cur_addr;
    logic                 found_in;
    logic [63:0]          found_addr_in;
    logic                 all_hit;
    mbps_pkg::t_match_cfg match_cfg;

    logic [7:0] win_byte [MAX_PATTERN_BYTES];
    logic       cell_hit [MAX_PATTERN_BYTES];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_mask   <= 16'hFFFF;
            r_len    <= 5'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mbps_pkg::CFG_PATTERN_LOW:  r_pat_lo <= i_cfg_data;
                mbps_pkg::CFG_PATTERN_HIGH: r_pat_hi <= i_cfg_data;
                mbps_pkg::CFG_COMPARE_MASK: r_mask   <= i_cfg_data[15:0];
                mbps_pkg::CFG_PATTERN_LEN:  r_len    <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Effective length: zero means one, clipped to the window cap
    always_comb begin
        eff_len = r_len;
        if (eff_len == 5'd0) begin
            eff_len = 5'd1;
        end
        if (eff_len > 5'(CAP)) begin
            eff_len = 5'(CAP);
        end
        match_cfg.pattern = {r_pat_hi, r_pat_lo};
        match_cfg.mask    = r_mask;
        match_cfg.len     = eff_len;
    end

    // Chain of window cells, newest byte enters cell 0
    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
        mbps_cell #(
            .POS (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (in_xfer),
            .i_byte  ((k == 0) ? i_data_byte : win_byte[(k == 0) ? 0 : k - 1]),
            .i_cfg   (match_cfg),
            .o_byte  (win_byte[k]),
            .o_hit   (cell_hit[k])
        );
    end

    always_comb begin
        all_hit = 1'b1;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            all_hit = all_hit & cell_hit[k];
        end
    end

    // Region tracking and first-match latch
    always_comb begin
        cur_addr      = i_first_of_region ? i_region_base : r_cur_addr;
        found_in      = i_first_of_region ? 1'b0 : r_found;
        found_addr_in = i_first_of_region ? 64'd0 : r_found_addr;
        if (i_first_of_region) begin
            n_fill = FW'(1);
        end else if (r_fill < FW'(MAX_PATTERN_BYTES)) begin
            n_fill = r_fill + FW'(1);
        end else begin
            n_fill = r_fill;
        end
        n_found      = found_in;
        n_found_addr = found_addr_in;
        if (!found_in && (CW'(n_fill) >= CW'(eff_len)) && all_hit) begin
            n_found      = 1'b1;
            n_found_addr = cur_addr - 64'(eff_len - 5'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_cur_addr   <= '0;
            r_found      <= 1'b0;
            r_found_addr <= '0;
        end else if (in_xfer) begin
            r_cur_addr <= cur_addr + 64'd1;
            if (i_last_of_region) begin
                r_fill       <= '0;
                r_found      <= 1'b0;
                r_found_addr <= '0;
            end else begin
                r_fill       <= n_fill;
                r_found      <= n_found;
                r_found_addr <= n_found_addr;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer && i_last_of_region) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_last_of_region) begin
            r_out_found <= n_found;
            r_out_addr  <= n_found ? n_found_addr : 64'd0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_match_found   = r_out_found;
    assign o_match_address = r_out_addr;

    // Checks
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no pending result");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(in_xfer && i_last_of_region))
        else $error("result without a last-byte transfer");

    a_miss_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_match_found) |-> (o_match_address == 64'd0))
        else $error("not-found result carries nonzero address");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_fill) <= CW'(MAX_PATTERN_BYTES))
        else $error("window fill beyond window depth");

endmodule
